// ===== rtl/kmsf_pkg.sv =====
// Shared types and constants for the keyword mask stream filter.
// Used by every module of the block; depends on nothing.
`default_nettype none

package kmsf_pkg;

   // configuration port
   localparam int CSR_INDEX_BITS = 3;
   localparam int CSR_DATA_BITS  = 48;

   typedef logic [CSR_INDEX_BITS-1:0] csr_index_type;
   typedef logic [CSR_DATA_BITS-1:0]  csr_data_type;

   localparam csr_index_type REG_BANNED_WORD_A = 3'd0;
   localparam csr_index_type REG_BANNED_WORD_B = 3'd1;
   localparam csr_index_type REG_BANNED_WORD_C = 3'd2;
   localparam csr_index_type REG_WORD_ENABLE   = 3'd3;
   localparam csr_index_type REG_MASK_CHAR     = 3'd4;

   localparam logic [7:0] MASK_CHAR_RESET = 8'd42;

   typedef struct packed {
      logic [47:0] banned_word_a;
      logic [47:0] banned_word_b;
      logic [47:0] banned_word_c;
      logic [2:0]  word_enable;
      logic [7:0]  mask_char;
   } cfg_type;

   typedef struct packed {
      logic [7:0] text_byte;
      logic       end_of_message;
   } req_type;

   typedef struct packed {
      logic [7:0] filtered_byte;
      logic       last_of_message;
   } rsp_type;

endpackage

`default_nettype wire

// ===== rtl/keyword_mask_stream_filter.sv =====
// Keyword mask stream filter: takes message text one byte per beat, holds back
// the last WORD_BYTES-1 bytes and compares the newest WORD_BYTES-byte window with
// three banned words (each with an enable bit). A matching window is dropped and
// MASK_LEN copies of the mask character are sent instead; a byte pushed out of the
// window is released as is, and end_of_message flushes all held bytes and marks
// the final beat with last_of_message. Rate: plain text flows at one byte per
// cycle while rsp_ready is high. A match sends MASK_LEN beats and a flush up to
// WORD_BYTES beats, which the result register sends one beat per cycle while
// rsp_ready is high; a byte arriving meanwhile waits in the input register.
// Configuration writes belong to idle periods. Depends on kmsf_pkg, kmsf_word_match
// and kmsf_result_list.
`default_nettype none

module keyword_mask_stream_filter #(
   parameter int WORD_BYTES = 6,
   parameter int MASK_LEN   = 3
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    req_valid,
   output logic                         req_ready,
   input  wire kmsf_pkg::req_type       req_data,
   output logic                         rsp_valid,
   input  wire logic                    rsp_ready,
   output kmsf_pkg::rsp_type            rsp_data,
   input  wire logic                    csr_write_enable,
   input  wire kmsf_pkg::csr_index_type csr_index,
   input  wire kmsf_pkg::csr_data_type  csr_data
);

   localparam int HOLD       = WORD_BYTES - 1;
   localparam int CNT_BITS   = $clog2(WORD_BYTES);
   localparam int RES_DEPTH  = (WORD_BYTES > MASK_LEN) ? WORD_BYTES : MASK_LEN;
   localparam int LIST_BITS  = $clog2(RES_DEPTH + 1);

   // configuration registers
   kmsf_pkg::cfg_type cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.banned_word_a <= '0;
         cfg_ff.banned_word_b <= '0;
         cfg_ff.banned_word_c <= '0;
         cfg_ff.word_enable   <= '0;
         cfg_ff.mask_char     <= kmsf_pkg::MASK_CHAR_RESET;
      end else if (csr_write_enable) begin
         case (csr_index)
            kmsf_pkg::REG_BANNED_WORD_A: cfg_ff.banned_word_a <= csr_data;
            kmsf_pkg::REG_BANNED_WORD_B: cfg_ff.banned_word_b <= csr_data;
            kmsf_pkg::REG_BANNED_WORD_C: cfg_ff.banned_word_c <= csr_data;
            kmsf_pkg::REG_WORD_ENABLE:   cfg_ff.word_enable   <= csr_data[2:0];
            kmsf_pkg::REG_MASK_CHAR:     cfg_ff.mask_char     <= csr_data[7:0];
            default: ;
         endcase
      end
   end

   // input register
   logic              in_valid_ff;
   kmsf_pkg::req_type in_data_ff;
   logic              can_load;
   logic              process;

   assign process   = in_valid_ff && can_load;
   assign req_ready = !in_valid_ff || can_load;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_valid && req_ready) begin
         in_valid_ff <= 1'b1;
      end else if (process) begin
         in_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_data_ff <= req_data;
      end
   end

   // held bytes, oldest first
   logic [7:0]          held_ff [HOLD];
   logic [7:0]          held_in [HOLD];
   logic [CNT_BITS-1:0] held_count_ff;
   logic [CNT_BITS-1:0] held_count_in;

   logic                    full;
   logic                    hit;
   logic                    eom;
   logic [7:0]              new_byte;
   logic [WORD_BYTES*8-1:0] window;
   logic [7:0]              src [RES_DEPTH];

   assign new_byte = in_data_ff.text_byte;
   assign eom      = in_data_ff.end_of_message;
   assign full     = (held_count_ff == CNT_BITS'(HOLD));

   for (genvar j = 0; j < HOLD; j++) begin : g_window
      assign window[(WORD_BYTES-1-j)*8 +: 8] = held_ff[j];
   end
   assign window[7:0] = new_byte;

   // held bytes followed by the new byte
   for (genvar j = 0; j < RES_DEPTH; j++) begin : g_src
      if (j < HOLD) begin : g_held
         assign src[j] = (CNT_BITS'(j) < held_count_ff) ? held_ff[j] : new_byte;
      end else begin : g_new
         assign src[j] = new_byte;
      end
   end

   logic match;

   kmsf_word_match #(
      .WORD_BYTES (WORD_BYTES)
   ) u_match (
      .window (window),
      .cfg    (cfg_ff),
      .hit    (match)
   );

   assign hit = full && match;

   // result beats for this item
   kmsf_pkg::rsp_type       res_entries [RES_DEPTH];
   logic [LIST_BITS-1:0]    res_count;

   always_comb begin
      for (int i = 0; i < RES_DEPTH; i++) begin
         if (hit) begin
            res_entries[i].filtered_byte   = cfg_ff.mask_char;
            res_entries[i].last_of_message = eom && (i == MASK_LEN - 1);
         end else begin
            res_entries[i].filtered_byte   = src[i];
            res_entries[i].last_of_message = eom && (LIST_BITS'(i) == LIST_BITS'(held_count_ff));
         end
      end
      if (hit) begin
         res_count = LIST_BITS'(MASK_LEN);
      end else if (eom) begin
         res_count = LIST_BITS'(held_count_ff) + LIST_BITS'(1);
      end else if (full) begin
         res_count = LIST_BITS'(1);
      end else begin
         res_count = '0;
      end
   end

   always_comb begin
      held_in       = held_ff;
      held_count_in = held_count_ff;
      if (process) begin
         if (hit || eom) begin
            held_count_in = '0;
         end else if (full) begin
            // release the oldest byte and advance the window
            for (int i = 0; i < HOLD - 1; i++) begin
               held_in[i] = held_ff[i+1];
            end
            held_in[HOLD-1] = new_byte;
         end else begin
            for (int i = 0; i < HOLD; i++) begin
               if (CNT_BITS'(i) == held_count_ff) begin
                  held_in[i] = new_byte;
               end
            end
            held_count_in = held_count_ff + CNT_BITS'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         held_count_ff <= '0;
      end else begin
         held_count_ff <= held_count_in;
      end
   end

   always_ff @(posedge clock) begin
      held_ff <= held_in;
   end

   kmsf_result_list #(
      .DEPTH (RES_DEPTH)
   ) u_results (
      .clock        (clock),
      .reset        (reset),
      .load         (process),
      .load_count   (res_count),
      .load_entries (res_entries),
      .can_load     (can_load),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_data     (rsp_data)
   );

endmodule

`default_nettype wire

// ===== rtl/kmsf_word_match.sv =====
// Compares the current byte window against the three banned words.
// Depends on kmsf_pkg (cfg_type).
`default_nettype none

module kmsf_word_match #(
   parameter int WORD_BYTES = 6
) (
   input  wire logic [WORD_BYTES*8-1:0] window,
   input  wire kmsf_pkg::cfg_type       cfg,
   output logic                         hit
);

   localparam int WIN_BITS = WORD_BYTES * 8;

   logic [63:0] word_a_ext;
   logic [63:0] word_b_ext;
   logic [63:0] word_c_ext;

   // zero-extend so window bytes above the register must be zero
   assign word_a_ext = {16'd0, cfg.banned_word_a};
   assign word_b_ext = {16'd0, cfg.banned_word_b};
   assign word_c_ext = {16'd0, cfg.banned_word_c};

   assign hit = (cfg.word_enable[0] && (window == word_a_ext[WIN_BITS-1:0]))
             || (cfg.word_enable[1] && (window == word_b_ext[WIN_BITS-1:0]))
             || (cfg.word_enable[2] && (window == word_c_ext[WIN_BITS-1:0]));

endmodule

`default_nettype wire

// ===== rtl/kmsf_result_list.sv =====
// Result register: holds the beats produced by one item and sends them in order.
// Depends on kmsf_pkg (rsp_type).
`default_nettype none

module kmsf_result_list #(
   parameter int DEPTH = 6
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       load,
   input  wire logic [$clog2(DEPTH+1)-1:0] load_count,
   input  wire kmsf_pkg::rsp_type          load_entries [DEPTH],
   output logic                            can_load,
   output logic                            rsp_valid,
   input  wire logic                       rsp_ready,
   output kmsf_pkg::rsp_type               rsp_data
);

   localparam int COUNT_BITS = $clog2(DEPTH+1);

   kmsf_pkg::rsp_type       entry_ff [DEPTH];
   kmsf_pkg::rsp_type       entry_in [DEPTH];
   logic [COUNT_BITS-1:0]   count_ff;
   logic [COUNT_BITS-1:0]   count_in;
   logic                    pop;

   assign rsp_valid = (count_ff != '0);
   assign rsp_data  = entry_ff[0];
   assign pop       = rsp_valid && rsp_ready;
   // room for a new item when empty or once the last pending beat leaves this cycle
   assign can_load  = (count_ff == '0) || ((count_ff == COUNT_BITS'(1)) && rsp_ready);

   always_comb begin
      entry_in = entry_ff;
      count_in = count_ff;
      if (load) begin
         entry_in = load_entries;
         count_in = load_count;
      end else if (pop) begin
         for (int i = 0; i < DEPTH - 1; i++) begin
            entry_in[i] = entry_ff[i+1];
         end
         count_in = count_ff - COUNT_BITS'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

endmodule

`default_nettype wire
